[hdl/ctb_pkg.sv]
`default_nettype none

package ctb_pkg;

   localparam int CAPACITY_DEFAULT = 1024;

   localparam int CMD_W    = 3;
   localparam int CHAR_W   = 8;
   localparam int INDEX_W  = 10;
   localparam int LEN_W    = 11;
   localparam int STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_LEFT      = 3'd1,
      CMD_RIGHT     = 3'd2,
      CMD_BACKSPACE = 3'd3,
      CMD_READ      = 3'd4,
      CMD_CLEAR     = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE = 2'd0,
      STAT_FULL = 2'd1,
      STAT_EDGE = 2'd2
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

endpackage

`default_nettype wire

[hdl/ctb_if.sv]
`default_nettype none

interface ctb_req_if;
   logic                         valid;
   logic                         ready;
   logic [ctb_pkg::CMD_W-1:0]    command;
   logic [ctb_pkg::CHAR_W-1:0]   char_in;
   logic [ctb_pkg::INDEX_W-1:0]  read_index;

   modport source (output valid, output command, output char_in, output read_index,
                   input ready);
   modport sink   (input valid, input command, input char_in, input read_index,
                   output ready);
endinterface

interface ctb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ctb_pkg::CHAR_W-1:0]    read_char;
   logic                          read_valid;
   logic [ctb_pkg::LEN_W-1:0]     text_length;
   logic [ctb_pkg::LEN_W-1:0]     cursor_pos;
   logic [ctb_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output read_char, output read_valid,
                   output text_length, output cursor_pos, output status,
                   input ready);
   modport sink   (input valid, input read_char, input read_valid,
                   input text_length, input cursor_pos, input status,
                   output ready);
endinterface

`default_nettype wire

[hdl/cursor_text_buffer.sv]
`default_nettype none

// Text buffer with an edit cursor, held as two stacks in two single-port-style
// memories with a registered read: the left memory holds the text before the
// cursor in order, the right memory holds the text after it with the character
// next to the cursor on top. Every request transaction (insert, cursor left,
// cursor right, backspace, read by index, clear, unused codes as no-ops)
// yields exactly one response transaction carrying the read character, the
// text length, the cursor position and a status. The memory read is launched
// in the cycle the request is accepted; the execute state then, once any
// pending response is taken, uses the read data, writes the memory and
// loads the response register, so a new request is taken only once the
// previous command has executed. The response register lets a request be
// accepted while the previous response is still waiting. Memory contents need
// no initialization; only entries below the stack counts are ever used.
module cursor_text_buffer #(
   parameter int CAPACITY = ctb_pkg::CAPACITY_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   ctb_req_if.sink   req_ch,
   ctb_rsp_if.source rsp_ch
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int WW = (CW > ctb_pkg::LEN_W) ? CW : ctb_pkg::LEN_W;

   ctb_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      left_count_ff, left_count_in;
   logic [CW-1:0]      right_count_ff, right_count_in;

   ctb_pkg::cmd_type           cmd_ff;
   logic [ctb_pkg::CHAR_W-1:0] char_ff;
   logic                       hit_left_ff, hit_right_ff;

   logic [ctb_pkg::CHAR_W-1:0] left_mem  [CAPACITY];
   logic [ctb_pkg::CHAR_W-1:0] right_mem [CAPACITY];
   logic [ctb_pkg::CHAR_W-1:0] left_rd_ff, right_rd_ff;
   logic [AW-1:0]              left_rd_addr, right_rd_addr;
   logic                       left_we, right_we;
   logic [ctb_pkg::CHAR_W-1:0] left_wr_data;

   logic                         rsp_valid_ff;
   logic [ctb_pkg::CHAR_W-1:0]   rsp_read_char_ff, rchar_w;
   logic                         rsp_read_valid_ff, rvalid_w;
   logic [ctb_pkg::LEN_W-1:0]    rsp_text_length_ff, rsp_cursor_pos_ff;
   ctb_pkg::status_type          rsp_status_ff, status_w;

   logic          req_accept, exec_go;
   logic [WW-1:0] total_w, idx_w, left_w, right_w, total_in_w, left_in_w;
   logic [WW-1:0] left_top_w, right_top_w, right_idx_w;

   assign req_ch.ready = (state_ff == ctb_pkg::ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign exec_go      = (state_ff == ctb_pkg::ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign left_w      = WW'(left_count_ff);
   assign right_w     = WW'(right_count_ff);
   assign total_w     = left_w + right_w;
   assign idx_w       = WW'(req_ch.read_index);
   assign left_top_w  = left_w - WW'(1);
   assign right_top_w = right_w - WW'(1);
   // right stack is stored top-down from the cursor, so index from the text end
   assign right_idx_w = total_w - idx_w - WW'(1);

   assign left_rd_addr  = (req_ch.command == ctb_pkg::CMD_READ) ? idx_w[AW-1:0]
                                                                : left_top_w[AW-1:0];
   assign right_rd_addr = (req_ch.command == ctb_pkg::CMD_READ) ? right_idx_w[AW-1:0]
                                                                : right_top_w[AW-1:0];

   // request decode captured at accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff       <= ctb_pkg::cmd_type'(req_ch.command);
         char_ff      <= req_ch.char_in;
         hit_left_ff  <= (idx_w < left_w);
         hit_right_ff <= (idx_w >= left_w) && (idx_w < total_w);
      end
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[left_count_ff[AW-1:0]] <= left_wr_data;
      end
      if (req_accept) begin
         left_rd_ff <= left_mem[left_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_count_ff[AW-1:0]] <= left_rd_ff;
      end
      if (req_accept) begin
         right_rd_ff <= right_mem[right_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ctb_pkg::ST_IDLE;
         left_count_ff  <= '0;
         right_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         left_count_ff  <= left_count_in;
         right_count_ff <= right_count_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      left_count_in  = left_count_ff;
      right_count_in = right_count_ff;
      left_we        = 1'b0;
      right_we       = 1'b0;
      left_wr_data   = char_ff;
      status_w       = ctb_pkg::STAT_DONE;
      rchar_w        = '0;
      rvalid_w       = 1'b0;
      unique case (state_ff)
         ctb_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ctb_pkg::ST_EXEC;
            end
         end
         ctb_pkg::ST_EXEC: begin
            if (exec_go) begin
               state_in = ctb_pkg::ST_IDLE;
               unique case (cmd_ff)
                  ctb_pkg::CMD_INSERT: begin
                     if (total_w >= WW'(CAPACITY)) begin
                        status_w = ctb_pkg::STAT_FULL;
                     end else begin
                        left_we       = 1'b1;
                        left_count_in = left_count_ff + CW'(1);
                     end
                  end
                  ctb_pkg::CMD_LEFT: begin
                     if (left_count_ff == '0) begin
                        status_w = ctb_pkg::STAT_EDGE;
                     end else begin
                        right_we       = 1'b1;
                        left_count_in  = left_count_ff - CW'(1);
                        right_count_in = right_count_ff + CW'(1);
                     end
                  end
                  ctb_pkg::CMD_RIGHT: begin
                     if (right_count_ff == '0) begin
                        status_w = ctb_pkg::STAT_EDGE;
                     end else begin
                        left_we        = 1'b1;
                        left_wr_data   = right_rd_ff;
                        left_count_in  = left_count_ff + CW'(1);
                        right_count_in = right_count_ff - CW'(1);
                     end
                  end
                  ctb_pkg::CMD_BACKSPACE: begin
                     if (left_count_ff == '0) begin
                        status_w = ctb_pkg::STAT_EDGE;
                     end else begin
                        left_count_in = left_count_ff - CW'(1);
                     end
                  end
                  ctb_pkg::CMD_READ: begin
                     if (hit_left_ff) begin
                        rchar_w  = left_rd_ff;
                        rvalid_w = 1'b1;
                     end else if (hit_right_ff) begin
                        rchar_w  = right_rd_ff;
                        rvalid_w = 1'b1;
                     end
                  end
                  ctb_pkg::CMD_CLEAR: begin
                     left_count_in  = '0;
                     right_count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ctb_pkg::ST_IDLE;
         end
      endcase
   end

   assign left_in_w  = WW'(left_count_in);
   assign total_in_w = left_in_w + WW'(right_count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_read_char_ff   <= rchar_w;
         rsp_read_valid_ff  <= rvalid_w;
         rsp_text_length_ff <= total_in_w[ctb_pkg::LEN_W-1:0];
         rsp_cursor_pos_ff  <= left_in_w[ctb_pkg::LEN_W-1:0];
         rsp_status_ff      <= status_w;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_char   = rsp_read_char_ff;
   assign rsp_ch.read_valid  = rsp_read_valid_ff;
   assign rsp_ch.text_length = rsp_text_length_ff;
   assign rsp_ch.cursor_pos  = rsp_cursor_pos_ff;
   assign rsp_ch.status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, left_count_ff} + {1'b0, right_count_ff}) <= (CW + 1)'(CAPACITY))
      else $error("stack counts exceed capacity");

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ctb_pkg::ST_EXEC))
      else $error("accepted transaction did not enter execute");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ctb_pkg::ST_EXEC))
      else $error("response raised without an executed command");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ch.ready) |-> !exec_go)
      else $error("pending response overwritten");

   a_edge_no_move: assert property (@(posedge clock) disable iff (reset)
      (exec_go && status_w != ctb_pkg::STAT_DONE) |=>
         ($stable(left_count_ff) && $stable(right_count_ff)))
      else $error("rejected command changed the counts");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
   import ctb_pkg::*;

   localparam int CAP          = CAPACITY_DEFAULT;
   localparam int SLOT_W       = $clog2(CAP);
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 100;

   // the two command codes the block treats as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct {
      logic [CHAR_W-1:0] read_char;
      logic              read_valid;
      logic [LEN_W-1:0]  text_length;
      logic [LEN_W-1:0]  cursor_pos;
      status_type        status;
   } edit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ctb_req_if req_bus ();
   ctb_rsp_if rsp_bus ();

   cursor_text_buffer #(.CAPACITY(CAP)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the text: chars before the cursor in order, chars after it
   // with the one next to the cursor on top
   logic [CHAR_W-1:0] left_chars [CAP];
   logic [CHAR_W-1:0] right_chars [CAP];
   int n_left = 0;
   int n_right = 0;

   edit_result_type expected_edits [$];
   int error_count = 0;
   int rsp_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_serial = 0;
   int hold_seen = 0;
   int hold_left = 0;

   function automatic edit_result_type apply_edit(input logic [CMD_W-1:0] cmd,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [INDEX_W-1:0] idx);
      edit_result_type r;
      int off;
      r.read_char  = '0;
      r.read_valid = 1'b0;
      r.status     = STAT_DONE;
      case (cmd)
         CMD_INSERT: begin
            if (n_left + n_right >= CAP) begin
               r.status = STAT_FULL;
            end else begin
               left_chars[SLOT_W'(n_left)] = ch;
               n_left++;
            end
         end
         CMD_LEFT: begin
            if (n_left == 0) begin
               r.status = STAT_EDGE;
            end else begin
               n_left--;
               right_chars[SLOT_W'(n_right)] = left_chars[SLOT_W'(n_left)];
               n_right++;
            end
         end
         CMD_RIGHT: begin
            if (n_right == 0) begin
               r.status = STAT_EDGE;
            end else begin
               n_right--;
               left_chars[SLOT_W'(n_left)] = right_chars[SLOT_W'(n_right)];
               n_left++;
            end
         end
         CMD_BACKSPACE: begin
            if (n_left == 0) r.status = STAT_EDGE;
            else n_left--;
         end
         CMD_READ: begin
            off = int'(idx) - n_left;
            if (int'(idx) < n_left) begin
               r.read_char  = left_chars[SLOT_W'(idx)];
               r.read_valid = 1'b1;
            end else if (off < n_right) begin
               r.read_char  = right_chars[SLOT_W'(n_right - 1 - off)];
               r.read_valid = 1'b1;
            end
         end
         CMD_CLEAR: begin
            n_left  = 0;
            n_right = 0;
         end
         default: ;
      endcase
      r.text_length = LEN_W'(n_left + n_right);
      r.cursor_pos  = LEN_W'(n_left);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= PRINT_LIMIT) begin
         $display("mismatch on %s at response %0d: got %0d, expected %0d",
                  what, rsp_count, got, want);
      end
   endtask

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                           input logic [INDEX_W-1:0] idx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid      <= 1'b0;
         req_bus.command    <= CMD_W'($urandom);
         req_bus.char_in    <= CHAR_W'($urandom);
         req_bus.read_index <= INDEX_W'($urandom);
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.char_in    <= ch;
      req_bus.read_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_edits.insert(expected_edits.size(), apply_edit(cmd, ch, idx));
   endtask

   // mostly edits and reads near the text, with a rare clear or spare code
   task automatic send_random_edit();
      int pick;
      int len;
      logic [CMD_W-1:0] cmd;
      logic [INDEX_W-1:0] idx;
      pick = $urandom_range(0, 99);
      len  = n_left + n_right;
      if ($urandom_range(0, 3) == 0 || len + 2 > CAP - 1) idx = INDEX_W'($urandom);
      else idx = INDEX_W'($urandom_range(0, len + 2));
      if (pick < 35) cmd = CMD_INSERT;
      else if (pick < 47) cmd = CMD_LEFT;
      else if (pick < 59) cmd = CMD_RIGHT;
      else if (pick < 69) cmd = CMD_BACKSPACE;
      else if (pick < 97) cmd = CMD_READ;
      else if (pick < 98) cmd = CMD_CLEAR;
      else if (pick < 99) cmd = CMD_SPARE_LO;
      else cmd = CMD_SPARE_HI;
      send_cmd(cmd, CHAR_W'($urandom), idx);
   endtask

   task automatic wait_drained();
      while (expected_edits.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_edges();
      send_cmd(CMD_LEFT, '0, '0);
      send_cmd(CMD_RIGHT, '0, '0);
      send_cmd(CMD_BACKSPACE, '0, '0);
      send_cmd(CMD_READ, '0, '0);
      send_cmd(CMD_READ, '1, '1);
      send_cmd(CMD_SPARE_LO, '1, '1);
      send_cmd(CMD_SPARE_HI, '0, '0);
      send_cmd(CMD_CLEAR, '0, '0);
   endtask

   task automatic test_basic_edits();
      send_cmd(CMD_INSERT, 8'h00, '0);
      send_cmd(CMD_INSERT, 8'hFF, '0);
      send_cmd(CMD_INSERT, 8'h5A, '1);
      send_cmd(CMD_INSERT, 8'hA5, '0);
      for (int i = 0; i < 4; i++) send_cmd(CMD_READ, '0, INDEX_W'(i));
      send_cmd(CMD_LEFT, '0, '0);
      send_cmd(CMD_LEFT, '0, '0);
      send_cmd(CMD_INSERT, 8'h41, '0);
      send_cmd(CMD_READ, '0, 10'd2);
      send_cmd(CMD_READ, '0, 10'd3);
      send_cmd(CMD_RIGHT, '0, '0);
      send_cmd(CMD_BACKSPACE, '0, '0);
      send_cmd(CMD_READ, '0, 10'd4);
      send_cmd(CMD_SPARE_HI, 8'h33, 10'd1);
      send_cmd(CMD_RIGHT, '0, '0);
      send_cmd(CMD_RIGHT, '0, '0);
      send_cmd(CMD_READ, '0, '1);
      send_cmd(CMD_CLEAR, '0, '0);
      send_cmd(CMD_READ, '0, '0);
   endtask

   task automatic test_full_buffer();
      for (int i = 0; i < CAP; i++) send_cmd(CMD_INSERT, CHAR_W'($urandom), '0);
      send_cmd(CMD_READ, '0, '0);
      send_cmd(CMD_READ, '0, '1);
      send_cmd(CMD_INSERT, 8'h7E, '0);
      for (int i = 0; i < 3; i++) send_cmd(CMD_LEFT, '0, '0);
      send_cmd(CMD_INSERT, 8'h7E, '0);
      // tail of the text now sits in the right stack
      send_cmd(CMD_READ, '0, '1);
      send_cmd(CMD_READ, '0, 10'd1021);
      send_cmd(CMD_RIGHT, '0, '0);
      send_cmd(CMD_BACKSPACE, '0, '0);
      send_cmd(CMD_INSERT, 8'hC3, '0);
      send_cmd(CMD_INSERT, 8'h3C, '0);
      send_cmd(CMD_READ, '0, 10'd1021);
      send_cmd(CMD_CLEAR, '0, '0);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      hold_serial++;
      for (int i = 0; i < 40; i++) send_random_edit();
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      rsp_idle_pct  = r_pct;
      for (int i = 0; i < count; i++) send_random_edit();
   endtask

   // response side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_seen != hold_serial) begin
         hold_seen     <= hold_serial;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      edit_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_edits.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = expected_edits.pop_front();
            if (rsp_bus.read_char !== want.read_char)
               report_mismatch("read_char", int'(rsp_bus.read_char),
                               int'(want.read_char));
            if (rsp_bus.read_valid !== want.read_valid)
               report_mismatch("read_valid", int'(rsp_bus.read_valid),
                               int'(want.read_valid));
            if (rsp_bus.text_length !== want.text_length)
               report_mismatch("text_length", int'(rsp_bus.text_length),
                               int'(want.text_length));
            if (rsp_bus.cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", int'(rsp_bus.cursor_pos),
                               int'(want.cursor_pos));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", int'(rsp_bus.status), int'(want.status));
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      req_bus.valid      = 1'b0;
      req_bus.command    = '0;
      req_bus.char_in    = '0;
      req_bus.read_index = '0;
      rsp_bus.ready      = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 26;
      rsp_idle_pct  = 61;
      test_empty_edges();
      test_basic_edits();
      test_full_buffer();
      test_random(65, 26, 61);
      test_random(65, 61, 26);
      test_backpressure();
      test_random(60, 0, 0);

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_edits.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
